>>> rtl/imh_pkg.sv
`timescale 1ns / 1ps

package imh_pkg;

	localparam int HANDLE_BITS = 6;
	localparam int HANDLES = 1 << HANDLE_BITS;
	localparam int CAPACITY = 64;
	localparam int KEY_BITS = 32;
	localparam int KEY_FIELD_BITS = 32;
	localparam int COUNT_FIELD_BITS = 7;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_CHANGE = 2'd1;
	localparam logic [1:0] OP_POP = 2'd2;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_FULL = 3'd1;
	localparam logic [2:0] ST_EMPTY = 3'd2;
	localparam logic [2:0] ST_PRESENT = 3'd3;
	localparam logic [2:0] ST_ABSENT = 3'd4;

	typedef struct packed {
		logic [1:0] op;
		logic [HANDLE_BITS-1:0] handle;
		logic [KEY_FIELD_BITS-1:0] key;
	} req_t;

	typedef struct packed {
		logic [HANDLE_BITS-1:0] out_handle;
		logic [KEY_FIELD_BITS-1:0] out_key;
		logic [2:0] status;
		logic [COUNT_FIELD_BITS-1:0] count;
	} rsp_t;

	typedef struct packed {
		logic gt;
	} cmp_res_t;

endpackage

>>> rtl/indexed_min_heap_core.sv
`timescale 1ns / 1ps

// Indexed binary min-heap of 64 handles, each with its own key, holding up to
// CAPACITY entries. Each request is one transfer on req and yields exactly one
// transfer on rsp; req_stall is high from acceptance until the response is
// taken. All slot, key and position accesses go through memories with a
// registered read port and a separate write port, and every key comparison
// goes through one shared comparator, so a sift-up level steps through S_UP,
// S_UP_K and S_UP_C, and a sift-down level through S_DOWN, S_D1, S_D2, S_D3,
// S_DC1, S_DC2 and S_DC3, taking S_D3, S_DC2 and S_DC3 only with two children.
// No clearing pass is needed after reset.
module indexed_min_heap_core #(
	parameter int CAPACITY = imh_pkg::CAPACITY,
	parameter int KEY_BITS = imh_pkg::KEY_BITS
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input imh_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output imh_pkg::rsp_t rsp
);

	localparam int HB = imh_pkg::HANDLE_BITS;
	localparam int NH = imh_pkg::HANDLES;
	localparam int SW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = SW + 2;
	localparam int KF = imh_pkg::KEY_FIELD_BITS;
	localparam int CF = imh_pkg::COUNT_FIELD_BITS;

	typedef enum logic [4:0] {
		S_IDLE, S_CHECK, S_POSRD, S_UP, S_UP_K, S_UP_C, S_DOWN, S_D1, S_D2, S_D3,
		S_DC1, S_DC2, S_DC3, S_PLACE, S_POP1, S_POP2, S_POP3, S_POP4, S_RESULT
	} state_t;

	state_t state_q;
	logic [1:0] op_q;
	logic [HB-1:0] h_q;
	logic [KEY_BITS-1:0] k_q;
	logic [SW-1:0] p_q;
	logic [CW-1:0] cnt_q;
	logic [NH-1:0] present_q;
	logic [HB-1:0] hl_q;
	logic [HB-1:0] hr_q;
	logic [KEY_BITS-1:0] kl_q;
	logic [KEY_BITS-1:0] kr_q;
	logic gtl_q;
	logic gtr_q;
	logic two_q;
	logic [HB-1:0] res_h_q;
	logic [KF-1:0] res_k_q;
	logic [2:0] res_st_q;

	logic [HB-1:0] heap_mem [CAPACITY];
	logic [KEY_BITS-1:0] key_mem [NH];
	logic [SW-1:0] pos_mem [NH];
	logic [HB-1:0] heap_rd_q;
	logic [KEY_BITS-1:0] key_rd_q;
	logic [SW-1:0] pos_rd_q;

	logic [SW-1:0] heap_ra;
	logic [HB-1:0] key_ra;
	logic [HB-1:0] pos_ra;
	logic heap_we;
	logic [SW-1:0] heap_wa;
	logic [HB-1:0] heap_wd;
	logic pos_we;
	logic [HB-1:0] pos_wa;
	logic [SW-1:0] pos_wd;
	logic key_we;

	logic [KEY_BITS-1:0] cmp_a;
	logic [KEY_BITS-1:0] cmp_b;
	imh_pkg::cmp_res_t cmp_res;

	logic [SW-1:0] par;
	logic [XW-1:0] lw;
	logic [XW-1:0] rw;
	logic [XW-1:0] cnt_x;
	logic [CW-1:0] cnt_m1;
	logic mv_l;
	logic mv_r;
	logic [KEY_BITS+KF-1:0] req_key_x;
	logic [KEY_BITS-1:0] req_key;
	logic [KF+KEY_BITS-1:0] k_out_x;
	logic [KF+KEY_BITS-1:0] kr_out_x;
	logic [CF+CW-1:0] cnt_out_x;

	assign req_key_x = {{KEY_BITS{1'b0}}, req.key};
	assign req_key = req_key_x[KEY_BITS-1:0];
	assign k_out_x = {{KF{1'b0}}, k_q};
	assign kr_out_x = {{KF{1'b0}}, key_rd_q};
	assign cnt_out_x = {{CF{1'b0}}, cnt_q};

	assign par = (p_q - 1'b1) >> 1;
	assign lw = {1'b0, p_q, 1'b1};
	assign rw = lw + 1'b1;
	assign cnt_x = XW'(cnt_q);
	assign cnt_m1 = cnt_q - 1'b1;

	imh_cmp #(.KEY_BITS(KEY_BITS)) u_cmp (
		.a(cmp_a),
		.b(cmp_b),
		.res(cmp_res)
	);

	always_comb begin
		cmp_a = k_q;
		cmp_b = kl_q;
		mv_l = 1'b0;
		mv_r = 1'b0;
		unique case (state_q)
			S_UP_C: begin
				cmp_a = key_rd_q;
				cmp_b = k_q;
			end
			S_DC1: begin
				mv_l = !two_q && cmp_res.gt;
			end
			S_DC2: begin
				cmp_b = kr_q;
			end
			S_DC3: begin
				cmp_a = kl_q;
				cmp_b = kr_q;
				mv_l = gtl_q && !cmp_res.gt;
				mv_r = gtr_q && cmp_res.gt;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		heap_ra = '0;
		key_ra = heap_rd_q;
		pos_ra = h_q;
		heap_we = 1'b0;
		heap_wa = p_q;
		heap_wd = h_q;
		pos_we = 1'b0;
		pos_wa = h_q;
		pos_wd = p_q;
		key_we = 1'b0;
		unique case (state_q)
			S_CHECK: begin
				if (op_q == imh_pkg::OP_INSERT) begin
					key_we = !present_q[h_q] && (cnt_q != CW'(CAPACITY));
				end else if (op_q == imh_pkg::OP_CHANGE) begin
					key_we = present_q[h_q];
				end
			end
			S_UP: heap_ra = par;
			S_UP_C: begin
				if (cmp_res.gt) begin
					heap_we = 1'b1;
					heap_wd = hl_q;
					pos_we = 1'b1;
					pos_wa = hl_q;
				end
			end
			S_DOWN: heap_ra = lw[SW-1:0];
			S_D1: heap_ra = rw[SW-1:0];
			S_DC1, S_DC3: begin
				if (mv_l || mv_r) begin
					heap_we = 1'b1;
					heap_wd = mv_l ? hl_q : hr_q;
					pos_we = 1'b1;
					pos_wa = mv_l ? hl_q : hr_q;
				end
			end
			S_PLACE: begin
				heap_we = 1'b1;
				pos_we = 1'b1;
			end
			S_POP2: heap_ra = cnt_m1[SW-1:0];
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		heap_rd_q <= heap_mem[heap_ra];
		key_rd_q <= key_mem[key_ra];
		pos_rd_q <= pos_mem[pos_ra];
		if (heap_we) begin
			heap_mem[heap_wa] <= heap_wd;
		end
		if (pos_we) begin
			pos_mem[pos_wa] <= pos_wd;
		end
		if (key_we) begin
			key_mem[h_q] <= k_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= '0;
			h_q <= '0;
			k_q <= '0;
			p_q <= '0;
			cnt_q <= '0;
			present_q <= '0;
			hl_q <= '0;
			hr_q <= '0;
			kl_q <= '0;
			kr_q <= '0;
			gtl_q <= 1'b0;
			gtr_q <= 1'b0;
			two_q <= 1'b0;
			res_h_q <= '0;
			res_k_q <= '0;
			res_st_q <= imh_pkg::ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q <= req.op;
						h_q <= req.handle;
						k_q <= req_key;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					res_h_q <= h_q;
					res_k_q <= '0;
					res_st_q <= imh_pkg::ST_OK;
					state_q <= S_RESULT;
					if (op_q == imh_pkg::OP_INSERT) begin
						if (present_q[h_q]) begin
							res_st_q <= imh_pkg::ST_PRESENT;
						end else if (cnt_q == CW'(CAPACITY)) begin
							res_st_q <= imh_pkg::ST_FULL;
						end else begin
							res_k_q <= k_out_x[KF-1:0];
							p_q <= cnt_q[SW-1:0];
							cnt_q <= cnt_q + 1'b1;
							state_q <= S_UP;
						end
					end else if (op_q == imh_pkg::OP_CHANGE) begin
						if (!present_q[h_q]) begin
							res_st_q <= imh_pkg::ST_ABSENT;
						end else begin
							res_k_q <= k_out_x[KF-1:0];
							state_q <= S_POSRD;
						end
					end else if (op_q == imh_pkg::OP_POP) begin
						res_h_q <= '0;
						if (cnt_q == '0) begin
							res_st_q <= imh_pkg::ST_EMPTY;
						end else begin
							state_q <= S_POP1;
						end
					end else begin
						res_h_q <= '0;
					end
				end
				S_POSRD: begin
					p_q <= pos_rd_q;
					state_q <= S_UP;
				end
				S_UP: begin
					if (p_q == '0) begin
						state_q <= (op_q == imh_pkg::OP_CHANGE) ? S_DOWN : S_PLACE;
					end else begin
						state_q <= S_UP_K;
					end
				end
				S_UP_K: begin
					hl_q <= heap_rd_q;
					state_q <= S_UP_C;
				end
				S_UP_C: begin
					if (cmp_res.gt) begin
						p_q <= par;
						state_q <= S_UP;
					end else begin
						state_q <= (op_q == imh_pkg::OP_CHANGE) ? S_DOWN : S_PLACE;
					end
				end
				S_DOWN: begin
					if (lw >= cnt_x) begin
						state_q <= S_PLACE;
					end else begin
						two_q <= (rw < cnt_x);
						state_q <= S_D1;
					end
				end
				S_D1: begin
					hl_q <= heap_rd_q;
					state_q <= S_D2;
				end
				S_D2: begin
					kl_q <= key_rd_q;
					hr_q <= heap_rd_q;
					state_q <= two_q ? S_D3 : S_DC1;
				end
				S_D3: begin
					kr_q <= key_rd_q;
					state_q <= S_DC1;
				end
				S_DC1: begin
					gtl_q <= cmp_res.gt;
					if (two_q) begin
						state_q <= S_DC2;
					end else begin
						if (mv_l) begin
							p_q <= lw[SW-1:0];
						end
						state_q <= S_PLACE;
					end
				end
				S_DC2: begin
					gtr_q <= cmp_res.gt;
					state_q <= S_DC3;
				end
				S_DC3: begin
					if (mv_l) begin
						p_q <= lw[SW-1:0];
						state_q <= S_DOWN;
					end else if (mv_r) begin
						p_q <= rw[SW-1:0];
						state_q <= S_DOWN;
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					present_q[h_q] <= 1'b1;
					state_q <= S_RESULT;
				end
				S_POP1: begin
					res_h_q <= heap_rd_q;
					state_q <= S_POP2;
				end
				S_POP2: begin
					res_k_q <= kr_out_x[KF-1:0];
					present_q[res_h_q] <= 1'b0;
					cnt_q <= cnt_m1;
					state_q <= (cnt_m1 == '0) ? S_RESULT : S_POP3;
				end
				S_POP3: begin
					h_q <= heap_rd_q;
					state_q <= S_POP4;
				end
				S_POP4: begin
					k_q <= key_rd_q;
					p_q <= '0;
					state_q <= S_DOWN;
				end
				S_RESULT: begin
					if (!rsp_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = (state_q == S_RESULT);
	assign rsp.out_handle = res_h_q;
	assign rsp.out_key = res_k_q;
	assign rsp.status = res_st_q;
	assign rsp.count = cnt_out_x[CF-1:0];

endmodule

>>> rtl/imh_cmp.sv
`timescale 1ns / 1ps

module imh_cmp #(
	parameter int KEY_BITS = imh_pkg::KEY_BITS
) (
	input logic [KEY_BITS-1:0] a,
	input logic [KEY_BITS-1:0] b,
	output imh_pkg::cmp_res_t res
);

	always_comb begin
		res.gt = (a > b);
	end

endmodule
